/* rtl/core/tqws_pkg.sv */
// Shared constants for the two-queue weighted service block.
// Depends on nothing; used by two_queue_weighted_service.
package tqws_pkg;

	localparam int QueueDepth = 16;
	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam int NumW = 32;
	localparam int LimitW = 4;

	localparam logic [LimitW-1:0] LimitReset = 4'd3;

	localparam logic CmdEnter = 1'b0;
	localparam logic CmdServe = 1'b1;

	localparam logic SelNormal = 1'b0;
	localparam logic SelPref = 1'b1;

	localparam logic [1:0] StEnqueued = 2'd0;
	localparam logic [1:0] StServed = 2'd1;
	localparam logic [1:0] StEmpty = 2'd2;
	localparam logic [1:0] StRejected = 2'd3;

endpackage

/* rtl/core/two_queue_weighted_service.sv */
// Two FIFO queues (normal, preferential) with weighted service between them.
// Depends on tqws_pkg for depth, widths and command/status codes.
//
// Channel   Direction  Handshake                  Payload
// request   in         start && !busy             command, queue_select, number_in
// result    out        done (one-cycle strobe)    status, served_number, served_from
// config    in         cfg_valid && cfg_ready     cfg_data (pref_run_limit)
//
// One request is taken every cycle; busy stays low.
// Each request gives one result: an input register, then the queue update and
// decision, then the result register.
// Queue storage is plain registers without reset; heads, tails, counts, run counter
// and valid bits are cleared by arst_n, and limit is reset to LimitReset.
// The receiver cannot stall; done marks each result for exactly one cycle.
module two_queue_weighted_service (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             command,
	input  logic                             queue_select,
	input  logic signed [tqws_pkg::NumW-1:0] number_in,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tqws_pkg::LimitW-1:0]      cfg_data,
	output logic                             done,
	output logic [1:0]                       status,
	output logic signed [tqws_pkg::NumW-1:0] served_number,
	output logic                             served_from
);

	localparam int PtrW = tqws_pkg::PtrW;
	localparam int CntW = tqws_pkg::CntW;
	localparam int NumW = tqws_pkg::NumW;

	// input stage
	logic            valid_s1;
	logic            cmd_s1;
	logic            sel_s1;
	logic [NumW-1:0] num_s1;

	// queue state
	logic [NumW-1:0] n_store_q [tqws_pkg::QueueDepth];
	logic [NumW-1:0] p_store_q [tqws_pkg::QueueDepth];
	logic [PtrW-1:0] n_head_q, n_tail_q, p_head_q, p_tail_q;
	logic [CntW-1:0] n_cnt_q, p_cnt_q;
	logic [tqws_pkg::LimitW-1:0] run_cnt_q;
	logic [tqws_pkg::LimitW-1:0] limit_q;

	// result stage
	logic            valid_s2;
	logic [1:0]      status_s2;
	logic [NumW-1:0] num_s2;
	logic            from_s2;

	logic has_n, has_p, n_full, p_full;
	logic push_n, push_p, serve, pop_n, pop_p, both_wait;
	logic [1:0] status_d;
	logic [NumW-1:0] num_d;

	function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
		if (p == PtrW'(tqws_pkg::QueueDepth - 1)) begin
			return '0;
		end
		return p + PtrW'(1);
	endfunction

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= command;
			sel_s1 <= queue_select;
			num_s1 <= number_in;
		end
	end

	always_comb begin
		has_n = n_cnt_q != '0;
		has_p = p_cnt_q != '0;
		n_full = n_cnt_q == CntW'(tqws_pkg::QueueDepth);
		p_full = p_cnt_q == CntW'(tqws_pkg::QueueDepth);
		push_n = valid_s1 && cmd_s1 == tqws_pkg::CmdEnter && sel_s1 == tqws_pkg::SelNormal
			&& !n_full;
		push_p = valid_s1 && cmd_s1 == tqws_pkg::CmdEnter && sel_s1 == tqws_pkg::SelPref
			&& !p_full;
		serve = valid_s1 && cmd_s1 == tqws_pkg::CmdServe;
		both_wait = has_n && has_p;
		// prefer the preferential queue until the run reaches the limit
		pop_p = serve && has_p && (!has_n || run_cnt_q < limit_q);
		pop_n = serve && has_n && !pop_p;

		num_d = '0;
		priority if (cmd_s1 == tqws_pkg::CmdEnter) begin
			status_d = (push_n || push_p) ? tqws_pkg::StEnqueued : tqws_pkg::StRejected;
		end else if (pop_p) begin
			status_d = tqws_pkg::StServed;
			num_d = p_store_q[p_head_q];
		end else if (pop_n) begin
			status_d = tqws_pkg::StServed;
			num_d = n_store_q[n_head_q];
		end else begin
			status_d = tqws_pkg::StEmpty;
		end
	end

	always_ff @(posedge clk) begin
		if (push_n) begin
			n_store_q[n_tail_q] <= num_s1;
		end
		if (push_p) begin
			p_store_q[p_tail_q] <= num_s1;
		end
		num_s2 <= num_d;
		status_s2 <= status_d;
		from_s2 <= pop_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_head_q <= '0;
			n_tail_q <= '0;
			n_cnt_q <= '0;
			p_head_q <= '0;
			p_tail_q <= '0;
			p_cnt_q <= '0;
			run_cnt_q <= '0;
			limit_q <= tqws_pkg::LimitReset;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (push_n) begin
				n_tail_q <= ptr_next(n_tail_q);
				n_cnt_q <= n_cnt_q + CntW'(1);
			end
			if (pop_n) begin
				n_head_q <= ptr_next(n_head_q);
				n_cnt_q <= n_cnt_q - CntW'(1);
			end
			if (push_p) begin
				p_tail_q <= ptr_next(p_tail_q);
				p_cnt_q <= p_cnt_q + CntW'(1);
			end
			if (pop_p) begin
				p_head_q <= ptr_next(p_head_q);
				p_cnt_q <= p_cnt_q - CntW'(1);
			end
			// only a contested serve moves the run counter
			if (serve && both_wait) begin
				run_cnt_q <= pop_n ? '0 : run_cnt_q + tqws_pkg::LimitW'(1);
			end
		end
	end

	assign done = valid_s2;
	assign status = status_s2;
	assign served_number = num_s2;
	assign served_from = from_s2;

	// every accepted request yields a result on done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("request without result");

	// a result that is not a service carries zero payload
	a_idle_payload: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != tqws_pkg::StServed |-> served_number == '0 && !served_from)
		else $error("payload set on non-service result");

	// normal service while both queues wait clears the run
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pop_n && both_wait |=> run_cnt_q == '0)
		else $error("run counter not cleared");

	// a queue never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_cnt_q <= CntW'(tqws_pkg::QueueDepth) && p_cnt_q <= CntW'(tqws_pkg::QueueDepth))
		else $error("queue occupancy overflow");

endmodule
